>>> rtl/spf_pkg.sv
package spf_pkg;

   // coordinate and result widths fixed by the port list
   localparam int COORD_W = 9;
   localparam int LEFT_OUT_W = 10;

   // defaults for the top level parameters
   localparam int GRID_DEF = 512;
   localparam int FRAC_BITS_DEF = 16;

   // command codes
   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_EDGE  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DIV_GO,
      ST_DIV,
      ST_WALK,
      ST_DRAIN,
      ST_QREAD,
      ST_QRESP
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic clr_start;
      logic clr_step;
      logic div_start;
      logic walk_step;
      logic q_read;
      logic q_resp;
   } ctl_type;

   // status from datapath to controller
   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic walk_last;
   } sts_type;

endpackage

>>> rtl/spf_div.sv
module spf_div #(
   parameter int DW = spf_pkg::COORD_W + spf_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DW-1:0]               dividend,
   input  logic [spf_pkg::COORD_W-1:0] divisor,
   output logic                        done,
   output logic [DW-1:0]               quotient
);

   localparam int CNW = $clog2(DW + 1);

   logic [CNW-1:0]              cnt_ff, cnt_in;
   logic [spf_pkg::COORD_W-1:0] rem_ff, rem_in;
   logic [DW-1:0]               quo_ff, quo_in;
   logic                        done_ff, done_in;
   logic [spf_pkg::COORD_W:0]   trial;
   logic                        fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial = {rem_ff, quo_ff[DW-1]};
      fits = trial >= {1'b0, divisor};
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNW'(DW);
         rem_in = '0;
         quo_in = dividend;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNW'(1);
         rem_in = fits ? spf_pkg::COORD_W'(trial - {1'b0, divisor})
                       : trial[spf_pkg::COORD_W-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
         done_in = cnt_ff == CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/spf_dp.sv
module spf_dp #(
   parameter int GRID = spf_pkg::GRID_DEF,
   parameter int FRAC_BITS = spf_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  spf_pkg::ctl_type              ctl,
   output spf_pkg::sts_type              sts,
   input  logic [spf_pkg::COORD_W-1:0]   req_start_x,
   input  logic [spf_pkg::COORD_W-1:0]   req_start_y,
   input  logic [spf_pkg::COORD_W-1:0]   req_end_x,
   input  logic [spf_pkg::COORD_W-1:0]   req_end_y,
   output logic [spf_pkg::COORD_W-1:0]   rsp_row,
   output logic [spf_pkg::LEFT_OUT_W-1:0] rsp_span_left,
   output logic [spf_pkg::COORD_W-1:0]   rsp_span_right,
   output logic                          rsp_span_valid
);

   localparam int CW_ = spf_pkg::COORD_W;
   localparam int AW = (GRID > 1) ? $clog2(GRID) : 1;
   localparam int LW = $clog2(GRID + 1);
   localparam int CMPW = (LW > CW_) ? LW : CW_;
   localparam int XW = CW_ + FRAC_BITS;

   // tables
   logic [LW-1:0]  left_mem [GRID];
   logic [CW_-1:0] right_mem [GRID];
   logic [LW-1:0]  left_rd_ff;
   logic [CW_-1:0] right_rd_ff;

   // edge and query registers
   logic [CW_-1:0] hi_y_ff, dx_ff, dy_ff, q_row_ff;
   logic           neg_ff, q_in_grid_ff;
   logic [XW-1:0]  x_ff, x_in, slope_ff;
   logic [CW_-1:0] row_ff, row_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic           pend_ff;
   logic [AW-1:0]  pend_row_ff;
   logic [CW_-1:0] pend_col_ff;

   // sorted endpoints
   logic           swap;
   logic [CW_-1:0] lo_x, lo_y, hi_x, hi_y;
   logic           row_in_grid;

   // divider
   logic           div_done;
   logic [XW-1:0]  quotient;

   // memory port selection
   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [LW-1:0]  wr_left;
   logic [CW_-1:0] wr_right;
   logic [CMPW-1:0] col_ext, left_ext, l_cmp, r_cmp;
   logic [LW-1:0]  l_val;
   logic [CW_-1:0] r_val;

   // order endpoints by y
   always_comb begin
      swap = req_end_y < req_start_y;
      lo_x = swap ? req_end_x : req_start_x;
      lo_y = swap ? req_end_y : req_start_y;
      hi_x = swap ? req_start_x : req_end_x;
      hi_y = swap ? req_start_y : req_end_y;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         hi_y_ff <= hi_y;
         neg_ff <= hi_x < lo_x;
         dx_ff <= (hi_x < lo_x) ? (lo_x - hi_x) : (hi_x - lo_x);
         dy_ff <= hi_y - lo_y;
         q_row_ff <= req_start_y;
         q_in_grid_ff <= 32'(req_start_y) < 32'(GRID);
      end
   end

   spf_div #(
      .DW(XW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (ctl.div_start),
      .dividend({dx_ff, {FRAC_BITS{1'b0}}}),
      .divisor (dy_ff),
      .done    (div_done),
      .quotient(quotient)
   );

   // slope magnitude, zero for a horizontal edge
   always_ff @(posedge clock) begin
      if (div_done) begin
         slope_ff <= (dy_ff == '0) ? '0 : quotient;
      end
   end

   // walk position
   assign row_in_grid = 32'(row_ff) < 32'(GRID);

   always_comb begin
      x_in = x_ff;
      row_in = row_ff;
      if (ctl.load) begin
         x_in = {lo_x, {FRAC_BITS{1'b0}}};
         row_in = lo_y;
      end else if (ctl.walk_step) begin
         x_in = neg_ff ? (x_ff - slope_ff) : (x_ff + slope_ff);
         row_in = row_ff + CW_'(1);
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      row_ff <= row_in;
   end

   // pending table update, one row behind the read
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= ctl.walk_step && row_in_grid;
      end
   end

   always_ff @(posedge clock) begin
      pend_row_ff <= AW'(row_ff);
      pend_col_ff <= x_ff[XW-1:FRAC_BITS];
   end

   // clear sweep counter
   always_comb begin
      clr_in = clr_ff;
      if (ctl.clr_start) begin
         clr_in = '0;
      end else if (ctl.clr_step) begin
         clr_in = clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // table write data: clear value or widened span
   always_comb begin
      col_ext = CMPW'(pend_col_ff);
      left_ext = CMPW'(left_rd_ff);
      wr_en = ctl.clr_step || pend_ff;
      wr_addr = ctl.clr_step ? clr_ff : pend_row_ff;
      if (ctl.clr_step) begin
         wr_left = LW'(GRID);
         wr_right = '0;
      end else begin
         wr_left = (col_ext < left_ext) ? LW'(col_ext) : left_rd_ff;
         wr_right = (pend_col_ff > right_rd_ff) ? pend_col_ff : right_rd_ff;
      end
      rd_en = (ctl.walk_step && row_in_grid) || ctl.q_read;
      rd_addr = ctl.q_read ? AW'(q_row_ff) : AW'(row_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_mem[wr_addr] <= wr_left;
         right_mem[wr_addr] <= wr_right;
      end
      if (rd_en) begin
         left_rd_ff <= left_mem[rd_addr];
         right_rd_ff <= right_mem[rd_addr];
      end
   end

   // status
   always_comb begin
      sts.clr_last = clr_ff == AW'(GRID - 1);
      sts.div_done = div_done;
      sts.walk_last = (row_ff == hi_y_ff) || ((32'(row_ff) + 32'd1) >= 32'(GRID));
   end

   // query result
   always_comb begin
      l_val = q_in_grid_ff ? left_rd_ff : LW'(GRID);
      r_val = q_in_grid_ff ? right_rd_ff : '0;
      l_cmp = CMPW'(l_val);
      r_cmp = CMPW'(r_val);
      rsp_row = q_row_ff;
      rsp_span_left = spf_pkg::LEFT_OUT_W'(l_val);
      rsp_span_right = r_val;
      rsp_span_valid = l_cmp <= r_cmp;
   end

endmodule

>>> rtl/spf_ctrl.sv
module spf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_cmd,
   output logic              busy,
   output spf_pkg::ctl_type  ctl,
   input  spf_pkg::sts_type  sts
);

   spf_pkg::state_type state_ff, state_in;
   spf_pkg::cmd_type   cmd;
   logic               accept;

   assign cmd = spf_pkg::cmd_type'(req_cmd);
   assign accept = start && (state_ff == spf_pkg::ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spf_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  spf_pkg::CMD_CLEAR: state_in = spf_pkg::ST_CLEAR;
                  spf_pkg::CMD_EDGE:  state_in = spf_pkg::ST_DIV_GO;
                  spf_pkg::CMD_QUERY: state_in = spf_pkg::ST_QREAD;
                  default:            state_in = spf_pkg::ST_IDLE;
               endcase
            end
         end
         spf_pkg::ST_CLEAR: begin
            if (sts.clr_last) state_in = spf_pkg::ST_IDLE;
         end
         spf_pkg::ST_DIV_GO: state_in = spf_pkg::ST_DIV;
         spf_pkg::ST_DIV: begin
            if (sts.div_done) state_in = spf_pkg::ST_WALK;
         end
         spf_pkg::ST_WALK: begin
            if (sts.walk_last) state_in = spf_pkg::ST_DRAIN;
         end
         spf_pkg::ST_DRAIN: state_in = spf_pkg::ST_IDLE;
         spf_pkg::ST_QREAD: state_in = spf_pkg::ST_QRESP;
         spf_pkg::ST_QRESP: state_in = spf_pkg::ST_IDLE;
         default:           state_in = spf_pkg::ST_IDLE;
      endcase
   end

   // state register, reset starts the clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spf_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath commands
   always_comb begin
      ctl = '0;
      busy = 1'b1;
      unique case (state_ff)
         spf_pkg::ST_IDLE: begin
            busy = 1'b0;
            ctl.load = accept;
            ctl.clr_start = accept && (cmd == spf_pkg::CMD_CLEAR);
         end
         spf_pkg::ST_CLEAR:  ctl.clr_step = 1'b1;
         spf_pkg::ST_DIV_GO: ctl.div_start = 1'b1;
         spf_pkg::ST_DIV:    ctl = '0;
         spf_pkg::ST_WALK:   ctl.walk_step = 1'b1;
         spf_pkg::ST_DRAIN:  ctl = '0;
         spf_pkg::ST_QREAD:  ctl.q_read = 1'b1;
         spf_pkg::ST_QRESP:  ctl.q_resp = 1'b1;
         default:            ctl = '0;
      endcase
   end

endmodule

>>> rtl/scanline_polygon_span_fill.sv
// query: ST_QREAD reads the tables, then ST_QRESP strobes the result and returns to idle
// clear: all GRID table rows written, one table row per cycle
// add edge: the serial divider gives the slope one bit a cycle, then the walk moves
// one row a cycle through the table's read and write ports
// reset starts the same clear sweep, busy high until it ends
// rsp_strobe marks each result for one cycle; the receiver cannot stall
module scanline_polygon_span_fill #(
   parameter int GRID = spf_pkg::GRID_DEF,
   parameter int FRAC_BITS = spf_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_cmd,
   input  logic [spf_pkg::COORD_W-1:0]    req_start_x,
   input  logic [spf_pkg::COORD_W-1:0]    req_start_y,
   input  logic [spf_pkg::COORD_W-1:0]    req_end_x,
   input  logic [spf_pkg::COORD_W-1:0]    req_end_y,
   output logic                           rsp_strobe,
   output logic [spf_pkg::COORD_W-1:0]    rsp_row,
   output logic [spf_pkg::LEFT_OUT_W-1:0] rsp_span_left,
   output logic [spf_pkg::COORD_W-1:0]    rsp_span_right,
   output logic                           rsp_span_valid
);

   spf_pkg::ctl_type ctl;
   spf_pkg::sts_type sts;

   // command sequencer
   spf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_cmd(req_cmd),
      .busy   (busy),
      .ctl    (ctl),
      .sts    (sts)
   );

   // tables, slope divider and edge walker
   spf_dp #(
      .GRID     (GRID),
      .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sts           (sts),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .rsp_row       (rsp_row),
      .rsp_span_left (rsp_span_left),
      .rsp_span_right(rsp_span_right),
      .rsp_span_valid(rsp_span_valid)
   );

   assign rsp_strobe = ctl.q_resp;

endmodule
